>>> rtl/lvwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvwf_pkg
// Shared types and constants of the lowest variance window finder.
// ----------------------------------------------------------------------------
package lvwf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  typedef struct packed {
    logic [15:0] pixel;
  } pixel_item_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  best_row;
    logic [9:0]  best_col;
    logic [31:0] best_sum;
    logic [62:0] best_score;
  } result_item_t;

  typedef struct packed {
    logic row0;
    logic sub_old;
    logic col0;
    logic sub_col;
    logic win;
    logic last;
  } item_flags_t;

  function automatic int bits_for(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

endpackage

>>> rtl/lvwf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvwf_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface lvwf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lvwf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvwf_queue
// Small register FIFO, used between the front and back parts and for results.
// ----------------------------------------------------------------------------
module lvwf_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4,
  localparam int AW   = lvwf_pkg::bits_for(DEPTH),
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head_data,
  output logic          empty,
  output logic          full
);
  import lvwf_pkg::*;

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == NW'(DEPTH));
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

>>> rtl/lvwf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvwf_front
// Configuration registers, raster counters and per-pixel classification.
// ----------------------------------------------------------------------------
module lvwf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 256,
  parameter int PIXEL_BITS = 16,
  localparam int CW    = lvwf_pkg::bits_for(MAX_WIDTH),
  localparam int RW    = lvwf_pkg::bits_for(MAX_HEIGHT),
  localparam int MW    = lvwf_pkg::bits_for(MAX_WINDOW),
  localparam int LSA_W = lvwf_pkg::bits_for(MAX_WINDOW * MAX_WIDTH),
  localparam int WV_W  = $clog2(MAX_WIDTH + 1),
  localparam int HV_W  = $clog2(MAX_HEIGHT + 1),
  localparam int NV_W  = $clog2(MAX_WINDOW + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  lvwf_stream_if.sink                            in_px,
  input  logic                                   q_full,
  input  logic                                   cfg_we,
  input  logic [lvwf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lvwf_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   push,
  output logic [PIXEL_BITS-1:0]                  it_p,
  output logic [LSA_W-1:0]                       it_slot,
  output logic [CW-1:0]                          it_c,
  output logic [CW-1:0]                          it_cn,
  output logic [RW-1:0]                          it_top,
  output logic [CW-1:0]                          it_left,
  output lvwf_pkg::item_flags_t                  it_f,
  output logic [NV_W-1:0]                        n_val,
  output logic                                   restart
);
  import lvwf_pkg::*;

  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam int N_RST = (MAX_WINDOW < 25) ? MAX_WINDOW : 25;

  logic [WV_W-1:0]  w_r;
  logic [HV_W-1:0]  h_r;
  logic [NV_W-1:0]  n_r;
  logic [CW-1:0]    c_r;
  logic [RW-1:0]    r_r;
  logic [MW-1:0]    rm_r;
  logic [LSA_W-1:0] rbase_r;
  logic             col_end, row_end, rm_end;

  assign restart     = cfg_we && (cfg_index == CFG_IMAGE_WIDTH ||
                                  cfg_index == CFG_IMAGE_HEIGHT ||
                                  cfg_index == CFG_WINDOW_SIZE);
  assign in_px.ready = !q_full;
  assign push        = in_px.valid && !q_full;
  assign n_val       = n_r;

  assign col_end = (int'(c_r) + 1 == int'(w_r));
  assign row_end = (int'(r_r) + 1 == int'(h_r));
  assign rm_end  = (int'(rm_r) + 1 == int'(n_r));

  assign it_p      = in_px.data.pixel[PIXEL_BITS-1:0];
  assign it_slot   = rbase_r + LSA_W'(c_r);
  assign it_c      = c_r;
  assign it_cn     = CW'(int'(c_r) - int'(n_r));
  assign it_top    = RW'(int'(r_r) + 1 - int'(n_r));
  assign it_left   = CW'(int'(c_r) + 1 - int'(n_r));
  assign it_f.row0    = (r_r == '0);
  assign it_f.sub_old = (int'(r_r) >= int'(n_r));
  assign it_f.col0    = (c_r == '0);
  assign it_f.sub_col = (int'(c_r) >= int'(n_r));
  assign it_f.win     = (int'(r_r) + 1 >= int'(n_r)) && (int'(c_r) + 1 >= int'(n_r));
  assign it_f.last    = col_end && row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WV_W'(W_RST);
      h_r <= HV_W'(H_RST);
      n_r <= NV_W'(N_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (cfg_data == '0) w_r <= WV_W'(1);
          else if (int'(cfg_data) > MAX_WIDTH) w_r <= WV_W'(MAX_WIDTH);
          else w_r <= WV_W'(cfg_data);
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data == '0) h_r <= HV_W'(1);
          else if (int'(cfg_data) > MAX_HEIGHT) h_r <= HV_W'(MAX_HEIGHT);
          else h_r <= HV_W'(cfg_data);
        end
        CFG_WINDOW_SIZE: begin
          if (cfg_data[8:0] == '0) n_r <= NV_W'(1);
          else if (int'(cfg_data[8:0]) > MAX_WINDOW) n_r <= NV_W'(MAX_WINDOW);
          else n_r <= NV_W'(cfg_data[8:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      c_r     <= '0;
      r_r     <= '0;
      rm_r    <= '0;
      rbase_r <= '0;
    end else if (push) begin
      if (!col_end) begin
        c_r <= c_r + 1'b1;
      end else begin
        c_r <= '0;
        if (row_end) begin
          r_r     <= '0;
          rm_r    <= '0;
          rbase_r <= '0;
        end else begin
          r_r <= r_r + 1'b1;
          if (rm_end) begin
            rm_r    <= '0;
            rbase_r <= '0;
          end else begin
            rm_r    <= rm_r + 1'b1;
            rbase_r <= rbase_r + LSA_W'(MAX_WIDTH);
          end
        end
      end
    end
  end
endmodule

>>> rtl/lvwf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvwf_back
// Line store, column sums, window accumulation, scoring and best search.
// ----------------------------------------------------------------------------
module lvwf_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 256,
  parameter int PIXEL_BITS = 16,
  localparam int CW    = lvwf_pkg::bits_for(MAX_WIDTH),
  localparam int RW    = lvwf_pkg::bits_for(MAX_HEIGHT),
  localparam int LSA_W = lvwf_pkg::bits_for(MAX_WINDOW * MAX_WIDTH),
  localparam int NV_W  = $clog2(MAX_WINDOW + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  restart,
  input  logic [NV_W-1:0]       n_val,
  input  logic                  q_empty,
  input  logic [PIXEL_BITS-1:0] hd_p,
  input  logic [LSA_W-1:0]      hd_slot,
  input  logic [CW-1:0]         hd_c,
  input  logic [CW-1:0]         hd_cn,
  input  logic [RW-1:0]         hd_top,
  input  logic [CW-1:0]         hd_left,
  input  lvwf_pkg::item_flags_t hd_f,
  output logic                  pop,
  lvwf_stream_if.source         out_res
);
  import lvwf_pkg::*;

  localparam longint PMAX = (64'd1 << PIXEL_BITS) - 1;
  localparam longint NMAX = MAX_WINDOW;
  localparam int CS_W  = $clog2(NMAX * PMAX + 1);
  localparam int CQ_W  = $clog2(NMAX * PMAX * PMAX + 1);
  localparam int WS_W  = $clog2(NMAX * NMAX * PMAX + 1);
  localparam int WQ_W  = $clog2(NMAX * NMAX * PMAX * PMAX + 1);
  localparam int NN_W  = $clog2(NMAX * NMAX + 1);
  localparam int H     = WQ_W / 2;
  localparam int SC_W  = NN_W + WQ_W;
  localparam int COL_W = CS_W + CQ_W;
  localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int RQ_DEPTH = 10;
  localparam int LC_W  = $clog2(RQ_DEPTH + 1);
  localparam int RES_W = $bits(result_item_t);

  logic [PIXEL_BITS-1:0] ls_mem [LS_DEPTH];
  logic [COL_W-1:0]      col_mem [MAX_WIDTH];

  logic [NN_W-1:0] nn_r;
  logic [LC_W-1:0] lasts_r;

  // stage 1
  logic                  v1_r;
  logic [PIXEL_BITS-1:0] p1_r, old1_r;
  logic [CW-1:0]         c1_r, cn1_r, left1_r;
  logic [RW-1:0]         top1_r;
  item_flags_t           f1_r;
  // stage 2
  logic                    v2_r;
  logic [PIXEL_BITS-1:0]   p2_r, old2_r;
  logic [2*PIXEL_BITS-1:0] psq2_r, osq2_r;
  logic [CW-1:0]           c2_r, left2_r;
  logic [RW-1:0]           top2_r;
  item_flags_t             f2_r;
  logic [COL_W-1:0]        colc_r, colcn_r;
  // stage 3
  logic            v3_r;
  logic [WS_W-1:0] ds3_r;
  logic [WQ_W-1:0] dq3_r;
  logic [CW-1:0]   left3_r;
  logic [RW-1:0]   top3_r;
  item_flags_t     f3_r;
  // window accumulators, read as stage 4
  logic            v4_r;
  logic [WS_W-1:0] wsum_r;
  logic [WQ_W-1:0] wsq_r;
  logic [CW-1:0]   left4_r;
  logic [RW-1:0]   top4_r;
  item_flags_t     f4_r;
  // stage 5
  logic                   v5_r;
  logic [NN_W+H-1:0]      plo5_r;
  logic [NN_W+WQ_W-H-1:0] phi5_r;
  logic [2*WS_W-1:0]      sq5_r;
  logic [WS_W-1:0]        ws5_r;
  logic [CW-1:0]          left5_r;
  logic [RW-1:0]          top5_r;
  item_flags_t            f5_r;
  // stage 6
  logic              v6_r;
  logic [SC_W-1:0]   a6_r;
  logic [2*WS_W-1:0] sq6_r;
  logic [WS_W-1:0]   ws6_r;
  logic [CW-1:0]     left6_r;
  logic [RW-1:0]     top6_r;
  item_flags_t       f6_r;
  // stage 7
  logic            v7_r;
  logic [SC_W-1:0] score7_r;
  logic [WS_W-1:0] ws7_r;
  logic [CW-1:0]   left7_r;
  logic [RW-1:0]   top7_r;
  item_flags_t     f7_r;
  // best record
  logic            best_valid_r;
  logic [SC_W-1:0] best_score_r;
  logic [WS_W-1:0] best_sum_r;
  logic [CW-1:0]   best_left_r;
  logic [RW-1:0]   best_top_r;

  logic [CS_W-1:0]  cs_new, cn_s;
  logic [CQ_W-1:0]  cq_new, cn_q;
  logic [COL_W-1:0] col_wdata;
  logic [WS_W-1:0]  wsum_nxt;
  logic [WQ_W-1:0]  wsq_nxt;
  logic             better, fin_valid;
  logic [SC_W-1:0]  fin_score;
  logic [WS_W-1:0]  fin_sum;
  logic [CW-1:0]    fin_left;
  logic [RW-1:0]    fin_top;
  logic             last_pop, rq_push, rq_pop, rq_empty, rq_full;
  result_item_t     res_word, rq_head;

  // hold a last pixel until the result queue has room for its result
  assign last_pop = pop && hd_f.last;
  assign pop      = !q_empty && (!hd_f.last || lasts_r < LC_W'(RQ_DEPTH));
  assign rq_push  = v7_r && f7_r.last;
  assign rq_pop   = out_res.valid && out_res.ready;

  assign out_res.valid = !rq_empty;
  assign out_res.data  = rq_head;

  lvwf_queue #(.DW(RES_W), .DEPTH(RQ_DEPTH)) u_res_queue (
    .clk, .rst_n, .push(rq_push), .push_data(res_word), .pop(rq_pop),
    .head_data(rq_head), .empty(rq_empty), .full(rq_full)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      old1_r          <= ls_mem[hd_slot];
      ls_mem[hd_slot] <= hd_p;
    end
  end

  always_comb begin
    cn_s = colcn_r[CS_W-1:0];
    cn_q = colcn_r[COL_W-1:CS_W];
    if (f2_r.row0) begin
      cs_new = CS_W'(p2_r);
      cq_new = CQ_W'(psq2_r);
    end else begin
      cs_new = colc_r[CS_W-1:0] + CS_W'(p2_r) - (f2_r.sub_old ? CS_W'(old2_r) : '0);
      cq_new = colc_r[COL_W-1:CS_W] + CQ_W'(psq2_r) -
               (f2_r.sub_old ? CQ_W'(osq2_r) : '0);
    end
    col_wdata = {cq_new, cs_new};
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      col_mem[c2_r] <= col_wdata;
    end
    colc_r  <= (v2_r && c2_r == c1_r)  ? col_wdata : col_mem[c1_r];
    colcn_r <= (v2_r && c2_r == cn1_r) ? col_wdata : col_mem[cn1_r];
  end

  assign wsum_nxt = (f3_r.col0 ? '0 : wsum_r) + ds3_r;
  assign wsq_nxt  = (f3_r.col0 ? '0 : wsq_r) + dq3_r;

  always_comb begin
    better    = f7_r.win && (!best_valid_r || score7_r < best_score_r);
    fin_valid = best_valid_r || better;
    fin_score = better ? score7_r : best_score_r;
    fin_sum   = better ? ws7_r : best_sum_r;
    fin_left  = better ? left7_r : best_left_r;
    fin_top   = better ? top7_r : best_top_r;
    res_word.found      = fin_valid;
    res_word.best_row   = fin_valid ? 10'(fin_top) : '0;
    res_word.best_col   = fin_valid ? 10'(fin_left) : '0;
    res_word.best_sum   = fin_valid ? 32'(fin_sum) : '0;
    res_word.best_score = fin_valid ? 63'(fin_score) : '0;
  end

  always_ff @(posedge clk) begin
    nn_r <= NN_W'(n_val) * NN_W'(n_val);

    p1_r <= hd_p;  c1_r <= hd_c;  cn1_r <= hd_cn;
    top1_r <= hd_top;  left1_r <= hd_left;  f1_r <= hd_f;

    p2_r   <= p1_r;
    old2_r <= old1_r;
    psq2_r <= p1_r * p1_r;
    osq2_r <= old1_r * old1_r;
    c2_r <= c1_r;  top2_r <= top1_r;  left2_r <= left1_r;  f2_r <= f1_r;

    ds3_r <= WS_W'(cs_new) - (f2_r.sub_col ? WS_W'(cn_s) : '0);
    dq3_r <= WQ_W'(cq_new) - (f2_r.sub_col ? WQ_W'(cn_q) : '0);
    top3_r <= top2_r;  left3_r <= left2_r;  f3_r <= f2_r;

    if (v3_r) begin
      wsum_r <= wsum_nxt;
      wsq_r  <= wsq_nxt;
    end
    top4_r <= top3_r;  left4_r <= left3_r;  f4_r <= f3_r;

    plo5_r <= nn_r * wsq_r[H-1:0];
    phi5_r <= nn_r * wsq_r[WQ_W-1:H];
    sq5_r  <= wsum_r * wsum_r;
    ws5_r  <= wsum_r;
    top5_r <= top4_r;  left5_r <= left4_r;  f5_r <= f4_r;

    a6_r  <= (SC_W'(phi5_r) << H) + SC_W'(plo5_r);
    sq6_r <= sq5_r;
    ws6_r <= ws5_r;
    top6_r <= top5_r;  left6_r <= left5_r;  f6_r <= f5_r;

    score7_r <= a6_r - SC_W'(sq6_r);
    ws7_r    <= ws6_r;
    top7_r <= top6_r;  left7_r <= left6_r;  f7_r <= f6_r;

    if (v7_r && better) begin
      best_score_r <= score7_r;
      best_sum_r   <= ws7_r;
      best_left_r  <= left7_r;
      best_top_r   <= top7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;  v2_r <= 1'b0;  v3_r <= 1'b0;  v4_r <= 1'b0;
      v5_r <= 1'b0;  v6_r <= 1'b0;  v7_r <= 1'b0;
      best_valid_r <= 1'b0;
      lasts_r      <= '0;
    end else begin
      v1_r <= pop;   v2_r <= v1_r;  v3_r <= v2_r;  v4_r <= v3_r;
      v5_r <= v4_r;  v6_r <= v5_r;  v7_r <= v6_r;
      if (restart || (v7_r && f7_r.last)) begin
        best_valid_r <= 1'b0;
      end else if (v7_r && better) begin
        best_valid_r <= 1'b1;
      end
      if (last_pop && !rq_pop) begin
        lasts_r <= lasts_r + 1'b1;
      end else if (!last_pop && rq_pop) begin
        lasts_r <= lasts_r - 1'b1;
      end
    end
  end

  a_last_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    last_pop |-> (lasts_r < LC_W'(RQ_DEPTH)))
    else $error("last pixel issued without room for its result");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full)
    else $error("result queue overflow");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |=> !best_valid_r)
    else $error("best record not cleared after a result");

  a_result_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (lasts_r != '0))
    else $error("result shown without a tracked last pixel");

  a_lasts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lasts_r <= LC_W'(RQ_DEPTH))
    else $error("pending result count out of range");
endmodule

>>> rtl/lowest_variance_window_finder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_variance_window_finder_core
// Streams a grayscale image in raster order and reports the square window
// with the lowest variance.
//
// in_px takes one pixel per transfer, one per cycle while the queue has room.
// out_res gives one result per image, transferred after the last pixel: found,
// top-left row/column, window sum and the score n*n*sumsq - sum*sum. The
// result passes through the scoring pipeline (column update, window
// accumulate, split multiply, subtract, compare). cfg_we/cfg_index/cfg_data
// write image_width, image_height and window_size; a write restarts the
// current image; the user writes only while idle, unchecked by the block.
// Reset restores 1024 x 1024 with a 25 pixel window and empties the block.
// Up to ten results, pending or in the pipeline, are held. When the
// receiver stalls with ten held, the next last pixel waits in a 4-entry
// queue; in_px.ready then drops once the queue fills.
// ----------------------------------------------------------------------------
module lowest_variance_window_finder_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 256,
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lvwf_stream_if.sink                     in_px,
  lvwf_stream_if.source                   out_res,
  input  logic                            cfg_we,
  input  logic [lvwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lvwf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lvwf_pkg::*;

  localparam int CW    = bits_for(MAX_WIDTH);
  localparam int RW    = bits_for(MAX_HEIGHT);
  localparam int LSA_W = bits_for(MAX_WINDOW * MAX_WIDTH);
  localparam int NV_W  = $clog2(MAX_WINDOW + 1);
  localparam int FL_W  = $bits(item_flags_t);
  localparam int ENT_W = PIXEL_BITS + LSA_W + 3 * CW + RW + FL_W;

  logic                  push, pop, q_empty, q_full, restart;
  logic [NV_W-1:0]       n_val;
  logic [PIXEL_BITS-1:0] it_p, hd_p;
  logic [LSA_W-1:0]      it_slot, hd_slot;
  logic [CW-1:0]         it_c, it_cn, it_left, hd_c, hd_cn, hd_left;
  logic [RW-1:0]         it_top, hd_top;
  item_flags_t           it_f, hd_f;
  logic [ENT_W-1:0]      push_data, head_data;

  lvwf_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WINDOW(MAX_WINDOW), .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk, .rst_n, .in_px, .q_full, .cfg_we, .cfg_index, .cfg_data,
    .push, .it_p, .it_slot, .it_c, .it_cn, .it_top, .it_left, .it_f,
    .n_val, .restart
  );

  assign push_data = {it_p, it_slot, it_c, it_cn, it_top, it_left, it_f};
  assign {hd_p, hd_slot, hd_c, hd_cn, hd_top, hd_left, hd_f} = head_data;

  lvwf_queue #(.DW(ENT_W), .DEPTH(4)) u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .head_data,
    .empty(q_empty), .full(q_full)
  );

  lvwf_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WINDOW(MAX_WINDOW), .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk, .rst_n, .restart, .n_val, .q_empty,
    .hd_p, .hd_slot, .hd_c, .hd_cn, .hd_top, .hd_left, .hd_f,
    .pop, .out_res
  );
endmodule

>>> tb/lowest_variance_window_finder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_variance_window_finder_core_tb
// Streams images of many shapes through the window finder and checks each
// result against an in-bench predictor. The predictor tracks the line store,
// the column sums and the running window sums at every pixel transfer, and
// queues the expected result. Both sides idle at random. Images cover
// windows that do not fit, flat images with tied scores, 0/65535 patterns,
// and register values out of range.
// ----------------------------------------------------------------------------
module lowest_variance_window_finder_core_tb;
  import lvwf_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXN = 256;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LIMIT = 2000000;

  typedef enum int {PIX_RANDOM, PIX_FLAT, PIX_EXTREME, PIX_NARROW} pix_kind_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lvwf_stream_if #(.T(pixel_item_t)) px_if();
  lvwf_stream_if #(.T(result_item_t)) res_if();

  lowest_variance_window_finder_core dut (
    .clk(clk), .rst_n(rst_n), .in_px(px_if.sink), .out_res(res_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  bit [10:0] img_w, img_h;
  bit [8:0] win_n;
  bit [15:0] line_mem[MAXN*MAXW];
  bit [63:0] col_sum[MAXW];
  bit [63:0] col_sq[MAXW];
  bit [63:0] win_sum, win_sq;
  int unsigned row_cnt, col_cnt;
  bit best_ok;
  int unsigned best_top, best_left;
  bit [63:0] best_total, best_val;

  result_item_t expected_results[$];
  bit [15:0] pixel_queue[$];

  int errors;
  int unsigned cycles;
  bit quiet;
  bit px_taken;

  function int unsigned clamp1(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function void restart_image();
    row_cnt = 0;
    col_cnt = 0;
    win_sum = 0;
    win_sq = 0;
    best_ok = 0;
    best_top = 0;
    best_left = 0;
    best_total = 0;
    best_val = 0;
  endfunction

  function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_IMAGE_WIDTH: img_w = val;
      CFG_IMAGE_HEIGHT: img_h = val;
      CFG_WINDOW_SIZE: win_n = val[8:0];
      default: return;
    endcase
    restart_image();
  endfunction

  function void pixel_step(bit [15:0] px);
    int unsigned w, h, n, r, c, slot;
    bit [63:0] p, old, nn, score;
    result_item_t res;
    w = clamp1(img_w, MAXW);
    h = clamp1(img_h, MAXH);
    n = clamp1(win_n, MAXN);
    r = row_cnt;
    c = col_cnt;
    p = px;
    if (c >= w || r >= h) begin
      restart_image();
      r = 0;
      c = 0;
    end
    slot = (r % n) * MAXW + c;
    old = line_mem[slot];
    if (r == 0) begin
      col_sum[c] = p;
      col_sq[c] = p * p;
    end else begin
      col_sum[c] += p;
      col_sq[c] += p * p;
      if (r >= n) begin
        col_sum[c] -= old;
        col_sq[c] -= old * old;
      end
    end
    line_mem[slot] = px;
    if (c == 0) begin
      win_sum = 0;
      win_sq = 0;
    end
    win_sum += col_sum[c];
    win_sq += col_sq[c];
    if (c >= n) begin
      win_sum -= col_sum[c-n];
      win_sq -= col_sq[c-n];
    end
    if (r + 1 >= n && c + 1 >= n) begin
      nn = 64'(n) * 64'(n);
      score = nn * win_sq - win_sum * win_sum;
      if (!best_ok || score < best_val) begin
        best_ok = 1;
        best_val = score;
        best_total = win_sum;
        best_top = r + 1 - n;
        best_left = c + 1 - n;
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    row_cnt = r;
    col_cnt = c;
    if (r >= h) begin
      res = '0;
      if (best_ok) begin
        res.found = 1'b1;
        res.best_row = best_top[9:0];
        res.best_col = best_left[9:0];
        res.best_sum = best_total[31:0];
        res.best_score = best_val[62:0];
      end
      expected_results.push_back(res);
      restart_image();
    end
  endfunction

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[lowest_variance_window_finder_core] ERROR");
      $finish;
    end
  end

  // predictor update on register writes and pixel transfers
  always @(posedge clk) begin
    if (rst_n && cfg_we) apply_register(cfg_index, cfg_data);
    px_taken <= px_if.valid && px_if.ready;
    if (rst_n && px_if.valid && px_if.ready) pixel_step(px_if.data.pixel);
  end

  // pixel driver
  always @(negedge clk) begin
    if (rst_n && (!px_if.valid || px_taken)) begin
      if (pixel_queue.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
        px_if.valid <= 1'b1;
        px_if.data <= pixel_queue.pop_front();
      end else begin
        px_if.valid <= 1'b0;
      end
    end
  end

  // result sink stall
  always @(negedge clk) begin
    if (rst_n) res_if.ready <= quiet || ($urandom_range(99) >= 28);
  end

  // result monitor
  always @(posedge clk) begin
    result_item_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", res_if.data);
      end else begin
        want = expected_results.pop_front();
        if (res_if.data !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, res_if.data);
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || px_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_images(int w, int h, int n, int images, pix_kind_t kind);
    int wc, hc, total;
    bit [15:0] base, v;
    wait_drained();
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
    cfg_write(CFG_WINDOW_SIZE, n);
    wc = clamp1(w, MAXW);
    hc = clamp1(h, MAXH);
    total = wc * hc * images;
    base = $urandom;
    for (int i = 0; i < total; i++) begin
      case (kind)
        PIX_FLAT: v = base;
        PIX_EXTREME: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        PIX_NARROW: v = base + $urandom_range(3);
        default: v = $urandom;
      endcase
      pixel_queue.push_back(v);
    end
  endtask

  initial begin
    int sent;
    int w, h, n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    px_if.valid = 1'b0;
    px_if.data = '0;
    res_if.ready = 1'b0;
    errors = 0;
    cycles = 0;
    quiet = 0;
    px_taken = 0;
    img_w = 1024;
    img_h = 1024;
    win_n = 25;
    restart_image();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(CFG_UNUSED, 11'h7FF);
    pixel_queue.push_back(16'hFFFF);
    run_images(1, 1, 1, 1, PIX_RANDOM);
    pixel_queue.push_back(16'h0000);
    run_images(1, 1, 2, 1, PIX_RANDOM);
    run_images(4, 3, 5, 1, PIX_RANDOM);
    run_images(5, 4, 2, 2, PIX_FLAT);
    run_images(0, 2, 1, 1, PIX_EXTREME);
    run_images(3, 0, 0, 1, PIX_EXTREME);
    run_images(3, 3, 511, 1, PIX_RANDOM);
    run_images(3, 2, 512, 1, PIX_RANDOM);
    run_images(1, 1, 1, 12, PIX_RANDOM);

    sent = 0;
    while (sent < 300) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      n = $urandom_range(1, 6);
      quiet = (sent > 100 && sent < 220);
      run_images(w, h, n, $urandom_range(1, 3), pix_kind_t'($urandom_range(3)));
      sent += pixel_queue.size();
    end
    quiet = 0;
    run_images(8, 8, 3, 2, PIX_NARROW);
    wait_drained();
    repeat (20) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("[lowest_variance_window_finder_core] OK");
    end else begin
      $display("[lowest_variance_window_finder_core] ERROR");
    end
    $finish;
  end

endmodule
